[sv/tcw_pkg.sv]
// Shared definitions for the text console writer: geometry, glyph codes,
// cell store request and result types. No dependencies.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_END        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] RESET_COLOR   = 8'h0F;
    localparam logic [CELL_W-1:0] CLEAR_CELL    = {RESET_COLOR, CH_SPACE};

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_result;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
    endfunction

endpackage

[sv/tcw_cell_store.sv]
// Cell store of the text console: one write port, one registered read port.
// Depends on tcw_pkg.
module tcw_cell_store (
    input  logic                             i_clk,
    input  tcw_pkg::t_ram_req                i_req,
    output logic [tcw_pkg::CELL_W-1:0]       o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tcw_seq.sv]
// Sequencer of the text console: cursor, clearing pass, put and read
// transactions, scroll walk over the cell store. Depends on tcw_pkg.
module tcw_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]      i_cell_row,
    input  logic [tcw_pkg::COL_W-1:0]      i_cell_col,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_color,
    input  logic                           i_out_free,
    input  logic [tcw_pkg::CELL_W-1:0]     i_rdata,
    output tcw_pkg::t_ram_req              o_ram_req,
    output tcw_pkg::t_result               o_result
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [tcw_pkg::ADDR_W-1:0]      r_ptr, n_ptr;
    logic [tcw_pkg::ADDR_W-1:0]      r_wr_addr, n_wr_addr;
    logic                            r_wr_pend, n_wr_pend;
    logic [tcw_pkg::ROW_W-1:0]       r_row, n_row;
    logic [tcw_pkg::COL_W-1:0]       r_col, n_col;
    logic                            r_rd_ok, n_rd_ok;
    logic [tcw_pkg::CELL_W-1:0]      r_res_data, n_res_data;

    logic                            accept;
    logic                            rd_in_range;
    logic [tcw_pkg::CHAR_W-1:0]      glyph;
    logic [tcw_pkg::COL_W:0]         col_inc;
    logic [tcw_pkg::ROW_W:0]         row_inc;
    logic                            wrap;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign rd_in_range = (i_cell_row < tcw_pkg::ROWS) && (i_cell_col < tcw_pkg::COLUMNS);
    assign col_inc     = {1'b0, r_col} + 1'b1;
    assign row_inc     = {1'b0, r_row} + 1'b1;
    assign wrap        = (i_char_code == tcw_pkg::CH_NEWLINE) ||
                         (col_inc >= tcw_pkg::COLUMNS);

    always_comb begin
        case (i_char_code)
            tcw_pkg::CH_END:     glyph = tcw_pkg::CH_UNDERSCORE;
            tcw_pkg::CH_NEWLINE: glyph = tcw_pkg::CH_SPACE;
            default:             glyph = i_char_code;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_wr_addr  = r_wr_addr;
        n_wr_pend  = r_wr_pend;
        n_row      = r_row;
        n_col      = r_col;
        n_rd_ok    = r_rd_ok;
        n_res_data = r_res_data;
        o_ram_req  = '0;
        o_result   = '0;

        case (r_state)
            S_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_ptr;
                o_ram_req.wdata = tcw_pkg::CLEAR_CELL;
                if (r_ptr == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == tcw_pkg::OP_READ) begin
                        o_ram_req.re    = rd_in_range;
                        o_ram_req.raddr = tcw_pkg::cell_addr(i_cell_row, i_cell_col);
                        n_rd_ok         = rd_in_range;
                        n_state         = S_READ;
                    end else begin
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = tcw_pkg::cell_addr(r_row, r_col);
                        o_ram_req.wdata = {i_color, glyph};
                        n_res_data      = '0;
                        n_state         = S_EMIT;
                        if (i_char_code != tcw_pkg::CH_END) begin
                            if (wrap) begin
                                n_col = '0;
                                if (row_inc >= tcw_pkg::ROWS) begin
                                    // bottom row left: scroll, cursor stays on last row
                                    n_row   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                                    n_ptr   = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row = row_inc[tcw_pkg::ROW_W-1:0];
                                end
                            end else begin
                                n_col = col_inc[tcw_pkg::COL_W-1:0];
                            end
                        end
                    end
                end
            end
            S_READ: begin
                n_res_data = r_rd_ok ? i_rdata : '0;
                n_state    = S_EMIT;
            end
            S_SCROLL: begin
                // read one row ahead, write back the previous read one row up
                if (r_wr_pend) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_wr_addr;
                    o_ram_req.wdata = i_rdata;
                end
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = r_ptr;
                n_wr_pend       = 1'b1;
                n_wr_addr       = tcw_pkg::ADDR_W'(r_ptr - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS));
                if (r_ptr == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
                    n_ptr   = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                    n_state = S_FILL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_FILL: begin
                o_ram_req.we = 1'b1;
                if (r_wr_pend) begin
                    o_ram_req.waddr = r_wr_addr;
                    o_ram_req.wdata = i_rdata;
                    n_wr_pend       = 1'b0;
                end else begin
                    o_ram_req.waddr = r_ptr;
                    o_ram_req.wdata = {i_color, tcw_pkg::CH_SPACE};
                    if (r_ptr == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
                        n_ptr   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_result.valid = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_ptr   = '0;
            end
        endcase

        o_result.data = r_res_data;
        o_result.row  = r_row;
        o_result.col  = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ptr     <= '0;
            r_wr_pend <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_wr_pend <= n_wr_pend;
            r_row     <= n_row;
            r_col     <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_rd_ok    <= n_rd_ok;
        r_res_data <= n_res_data;
    end

endmodule

[sv/text_console_writer_unit.sv]
// Top level of the text console writer: color register, output register,
// sequencer and cell store. Depends on tcw_pkg, tcw_cell_store, tcw_seq.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_operation i_char_code i_cell_row/col
//  out      | output    | o_out_valid / i_out_stall | o_cell_data o_cursor_row o_cursor_col
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (text color)
//
// A put passes through S_EMIT, a read through S_READ and then S_EMIT (registered read
// of the cell store port). A put that leaves the bottom row adds a scroll walk
// (S_SCROLL, S_FILL) over the single write port of the cell store.
// After reset a clearing pass writes every cell with o_in_stall high;
// configuration writes are taken throughout.
// One transaction in flight; a held result stalls the sequencer only once done.
module text_console_writer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]      i_cell_row,
    input  logic [tcw_pkg::COL_W-1:0]      i_cell_col,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tcw_pkg::CELL_W-1:0]     o_cell_data,
    output logic [tcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]      o_cursor_col,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_cfg_data
);

    logic [tcw_pkg::CHAR_W-1:0]  r_color;
    logic                        r_out_valid;
    logic [tcw_pkg::CELL_W-1:0]  r_out_data;
    logic [tcw_pkg::ROW_W-1:0]   r_out_row;
    logic [tcw_pkg::COL_W-1:0]   r_out_col;

    logic                        out_free;
    tcw_pkg::t_ram_req           ram_req;
    tcw_pkg::t_result            result;
    logic [tcw_pkg::CELL_W-1:0]  rdata;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    tcw_cell_store u_store (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    tcw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_cell_row  (i_cell_row),
        .i_cell_col  (i_cell_col),
        .i_color     (r_color),
        .i_out_free  (out_free),
        .i_rdata     (rdata),
        .o_ram_req   (ram_req),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= tcw_pkg::RESET_COLOR;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_data;
            end
            if (result.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_data <= result.data;
            r_out_row  <= result.row;
            r_out_col  <= result.col;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_data  = r_out_data;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

`ifndef SYNTHESIS
    // one transaction at a time: the sequencer leaves idle on acceptance
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // a new result never overwrites one that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded into a stalled output register");

    // cursor reported inside the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_cursor_row < tcw_pkg::ROWS) && (o_cursor_col < tcw_pkg::COLUMNS)))
        else $error("cursor outside the screen");

    // no cell store write once idle and no transaction accepted
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && !i_in_valid) |-> !ram_req.we)
        else $error("cell store written while idle");
`endif

endmodule
